// ===== rtl/timed_event_replay_buffer_top_defines.svh =====
// assertion macros shared by the replay buffer rtl
`ifndef TIMED_EVENT_REPLAY_BUFFER_TOP_DEFINES_SVH
`define TIMED_EVENT_REPLAY_BUFFER_TOP_DEFINES_SVH

// checked on every clock, quiet while reset is high
`define TERB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every clock, reset included
`define TERB_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/terb_pkg.sv =====
// package: sizes, codes and controller/datapath interface types
package terb_pkg;

  localparam int EVENT_DEPTH = 64;
  localparam int MAX_RESULTS = 64;
  localparam int IDX_W       = $clog2(EVENT_DEPTH);
  localparam int CNT_W       = $clog2(EVENT_DEPTH + 1);
  localparam int NRES_W      = $clog2(MAX_RESULTS + 1);
  localparam int Q_W         = 32;

  typedef enum logic [2:0] {
    OP_TICK   = 3'd0,
    OP_RECORD = 3'd1,
    OP_PLAY   = 3'd2,
    OP_PAUSE  = 3'd3,
    OP_CLEAR  = 3'd4,
    OP_RESET  = 3'd5,
    OP_REWIND = 3'd6
  } op_t;

  typedef enum logic [1:0] {
    KIND_ACK   = 2'd0,
    KIND_EVENT = 2'd1,
    KIND_FWD   = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NOT_PAUSED = 2'd1,
    ST_FULL       = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_EVAL,
    S_FLUSH
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic latch;   // capture the incoming item
    logic do_op;   // execute a non-tick opcode and acknowledge
    logic fwd;     // forward tick_dt as a time event
    logic add_dt;  // add tick_dt to the accumulator, start a replay
    logic rd;      // read the store at the read pointer
    logic take;    // replay the event just read
    logic flush;   // send the pending event as the final result
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    op_t  op;
    logic valid_op;
    logic playing;
    logic at_end;
    logic n_full;
    logic go;
  } stat_t;

endpackage

// ===== rtl/terb_ctrl.sv =====
// controller state machine for the replay buffer
module terb_ctrl import terb_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  stat_t stat,
  output cmd_t  cmd,
  output logic  busy
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (stat.op == OP_TICK && stat.valid_op && stat.playing && !stat.at_end) begin
          state_next = S_READ;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_READ: begin
        if (stat.at_end || stat.n_full) state_next = S_FLUSH;
        else state_next = S_EVAL;
      end
      S_EVAL: begin
        if (stat.go) state_next = S_READ;
        else state_next = S_FLUSH;
      end
      S_FLUSH: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd  = '0;
    busy = (state != S_IDLE);
    case (state)
      S_IDLE: cmd.latch = start;
      S_EXEC: begin
        if (stat.valid_op) begin
          if (stat.op == OP_TICK) begin
            if (stat.playing && stat.at_end) cmd.fwd = 1'b1;
            if (stat.playing && !stat.at_end) cmd.add_dt = 1'b1;
          end else begin
            cmd.do_op = 1'b1;
          end
        end
      end
      S_READ: begin
        if (!(stat.at_end || stat.n_full)) cmd.rd = 1'b1;
      end
      S_EVAL: cmd.take = stat.go;
      S_FLUSH: cmd.flush = 1'b1;
      default: cmd = '0;
    endcase
  end

endmodule

// ===== rtl/terb_dpath.sv =====
// datapath: event store, pointers, time accumulator and result registers
`include "timed_event_replay_buffer_top_defines.svh"

module terb_dpath import terb_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  cmd_t           cmd,
  output stat_t          stat,
  input  logic [2:0]     opcode,
  input  logic           event_is_time,
  input  logic [Q_W-1:0] event_delta,
  input  logic [Q_W-1:0] event_payload,
  input  logic [Q_W-1:0] tick_dt,
  output logic           result_valid,
  output logic [1:0]     result_kind,
  output logic           out_is_time,
  output logic [Q_W-1:0] out_delta,
  output logic [Q_W-1:0] out_payload,
  output logic [1:0]     status,
  output logic           finished,
  output logic           last
);

  // captured item
  logic [2:0]     q_op;
  logic           q_is_time;
  logic [Q_W-1:0] q_delta;
  logic [Q_W-1:0] q_payload;
  logic [Q_W-1:0] q_dt;

  // control state
  logic [CNT_W-1:0]  event_count;
  logic [CNT_W-1:0]  read_pointer;
  logic [Q_W-1:0]    acc;
  logic              playing;
  logic [NRES_W-1:0] n_res;
  logic              pend_valid;

  // store and read port
  logic [Q_W:0]   event_store [EVENT_DEPTH];
  logic           rd_is_time;
  logic [Q_W-1:0] rd_val;

  // event waiting to learn whether it is the final result
  logic           pend_is_time;
  logic [Q_W-1:0] pend_delta;
  logic [Q_W-1:0] pend_payload;
  logic           pend_finished;

  // opcode effects
  logic [CNT_W-1:0] count_next;
  logic [CNT_W-1:0] rp_next;
  logic             playing_next;
  logic [Q_W-1:0]   acc_op_next;
  status_t          ack_status;
  logic             store_we;
  logic [Q_W:0]     acc_sum;
  logic [CNT_W-1:0] rp_inc;
  logic             at_end;
  logic             result_valid_next;

  assign at_end = (read_pointer >= event_count);
  assign rp_inc = read_pointer + CNT_W'(1);
  assign acc_sum = {1'b0, acc} + {1'b0, q_dt};

  // a replayed event goes out one step late, only once a pending one exists
  assign result_valid_next = cmd.do_op || cmd.fwd || ((cmd.take || cmd.flush) && pend_valid);

  always_comb begin
    stat.op       = op_t'(q_op);
    stat.valid_op = (q_op <= 3'(OP_REWIND));
    stat.playing  = playing;
    stat.at_end   = at_end;
    stat.n_full   = (n_res == NRES_W'(MAX_RESULTS));
    stat.go       = !(rd_is_time && (rd_val > acc));
  end

  always_comb begin
    count_next   = event_count;
    rp_next      = read_pointer;
    playing_next = playing;
    acc_op_next  = acc;
    ack_status   = ST_OK;
    store_we     = 1'b0;
    case (op_t'(q_op))
      OP_RECORD: begin
        if (playing) begin
          ack_status = ST_NOT_PAUSED;
        end else if (event_count >= CNT_W'(EVENT_DEPTH)) begin
          ack_status = ST_FULL;
        end else begin
          store_we   = 1'b1;
          count_next = event_count + CNT_W'(1);
          rp_next    = event_count + CNT_W'(1);
        end
      end
      OP_PLAY: begin
        if (playing) ack_status = ST_NOT_PAUSED;
        else playing_next = 1'b1;
      end
      OP_PAUSE: playing_next = 1'b0;
      OP_CLEAR: begin
        if (playing) begin
          ack_status = ST_NOT_PAUSED;
        end else begin
          count_next = '0;
          rp_next    = '0;
        end
      end
      OP_RESET: begin
        playing_next = 1'b0;
        count_next   = '0;
        rp_next      = '0;
      end
      OP_REWIND: begin
        rp_next     = '0;
        acc_op_next = '0;
      end
      default: ack_status = ST_OK;
    endcase
  end

  // store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.do_op && store_we) begin
      event_store[event_count[IDX_W-1:0]] <= q_is_time
        ? {1'b1, q_delta} : {1'b0, q_payload};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      {rd_is_time, rd_val} <= event_store[read_pointer[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      q_op      <= opcode;
      q_is_time <= event_is_time;
      q_delta   <= event_delta;
      q_payload <= event_payload;
      q_dt      <= tick_dt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      event_count  <= '0;
      read_pointer <= '0;
      acc          <= '0;
      playing      <= 1'b0;
      n_res        <= '0;
      pend_valid   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= result_valid_next;
      if (cmd.do_op) begin
        event_count  <= count_next;
        read_pointer <= rp_next;
        playing      <= playing_next;
        acc          <= acc_op_next;
      end
      if (cmd.add_dt) begin
        acc        <= acc_sum[Q_W] ? '1 : acc_sum[Q_W-1:0];
        n_res      <= '0;
        pend_valid <= 1'b0;
      end
      if (cmd.take) begin
        if (rd_is_time) acc <= acc - rd_val;
        read_pointer <= rp_inc;
        n_res        <= n_res + NRES_W'(1);
        pend_valid   <= 1'b1;
      end
      if (cmd.flush) begin
        pend_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      pend_is_time  <= rd_is_time;
      pend_delta    <= rd_is_time ? rd_val : '0;
      pend_payload  <= rd_is_time ? '0 : rd_val;
      pend_finished <= (rp_inc >= event_count);
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (cmd.do_op) begin
      result_kind <= KIND_ACK;
      out_is_time <= 1'b0;
      out_delta   <= '0;
      out_payload <= '0;
      status      <= ack_status;
      finished    <= (rp_next >= count_next);
      last        <= 1'b1;
    end else if (cmd.fwd) begin
      result_kind <= KIND_FWD;
      out_is_time <= 1'b1;
      out_delta   <= q_dt;
      out_payload <= '0;
      status      <= ST_OK;
      finished    <= at_end;
      last        <= 1'b1;
    end else if (cmd.take || cmd.flush) begin
      result_kind <= KIND_EVENT;
      out_is_time <= pend_is_time;
      out_delta   <= pend_delta;
      out_payload <= pend_payload;
      status      <= ST_OK;
      finished    <= pend_finished;
      last        <= cmd.flush;
    end
  end

  `TERB_ASSERT(a_rp_bounded, read_pointer <= event_count, "read pointer past stored events")
  `TERB_ASSERT(a_count_bounded, event_count <= CNT_W'(EVENT_DEPTH), "event count past depth")
  `TERB_ASSERT(a_last_clears, result_valid && last |-> !pend_valid, "event pending after last")
  `TERB_ASSERT(a_take_valid, cmd.take |-> !at_end && (n_res < NRES_W'(MAX_RESULTS)),
    "replay beyond store or result limit")
  `TERB_ASSERT_ALWAYS(a_reset_quiet, rst |=> !result_valid, "result right after reset")

endmodule

// ===== rtl/timed_event_replay_buffer_top.sv =====
// top level of the timed event replay buffer
//
// channel | direction | handshake                         | fields
// item    | in        | start && !busy                    | opcode, event_is_time, event_delta,
//         |           |                                   | event_payload, tick_dt
// result  | out       | result_valid, one cycle per result| result_kind, out_is_time, out_delta,
//         |           |                                   | out_payload, status, finished, last
//
// a valid non-tick item is acknowledged once captured and executed, and busy drops with it
// a tick replays stored events one at a time (store read, then compare against the accumulator)
// and holds busy until the store ends, a time event exceeds the accumulator or results are full
// a replayed event is held pending and shown once the next decision is made, so that last can be set correctly
// reset is synchronous; store contents need no clearing, only entries below the count are read
// the receiver cannot stall: every result is taken in the cycle it is shown
`include "timed_event_replay_buffer_top_defines.svh"

module timed_event_replay_buffer_top import terb_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  // item side
  input  logic           start,
  output logic           busy,
  input  logic [2:0]     opcode,
  input  logic           event_is_time,
  input  logic [Q_W-1:0] event_delta,
  input  logic [Q_W-1:0] event_payload,
  input  logic [Q_W-1:0] tick_dt,
  // result side
  output logic           result_valid,
  output logic [1:0]     result_kind,
  output logic           out_is_time,
  output logic [Q_W-1:0] out_delta,
  output logic [Q_W-1:0] out_payload,
  output logic [1:0]     status,
  output logic           finished,
  output logic           last
);

  cmd_t  cmd;   // controller commands
  stat_t stat;  // datapath status

  // sequencing: capture, execute, read/evaluate loop, final flush
  terb_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // store, pointers, accumulator and result registers
  terb_dpath u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .opcode        (opcode),
    .event_is_time (event_is_time),
    .event_delta   (event_delta),
    .event_payload (event_payload),
    .tick_dt       (tick_dt),
    .result_valid  (result_valid),
    .result_kind   (result_kind),
    .out_is_time   (out_is_time),
    .out_delta     (out_delta),
    .out_payload   (out_payload),
    .status        (status),
    .finished      (finished),
    .last          (last)
  );

  // no item is taken while a tick replay or an acknowledge is in flight
  `TERB_ASSERT(a_busy_after_accept, start && !busy |=> busy, "item accepted but not busy")
  `TERB_ASSERT(a_idle_after_last, result_valid && last |-> !busy, "busy after final result")
  `TERB_ASSERT(a_no_result_at_rest, !busy && !$past(busy) |-> !result_valid,
    "result with no item in flight")

endmodule
